// ----- hw/rtl/bess_pkg.sv -----
// Shared types and constants for the curve even-spacing sampler.
// Used by the controller, the datapath and the top level.
`default_nettype none
package bess_pkg;

  localparam int unsigned StepsDef  = 1000;
  localparam int unsigned CoordW    = 24;
  localparam int unsigned OpW       = 5;
  localparam int unsigned NumOps    = 18;
  localparam int unsigned SqrtIters = 25;
  localparam int unsigned SqCntW    = 5;

  // datapath micro-operations, one per cycle of the multiply phase
  localparam logic [OpW-1:0] OpUU      = 5'd0;
  localparam logic [OpW-1:0] OpUT      = 5'd1;
  localparam logic [OpW-1:0] OpTT      = 5'd2;
  localparam logic [OpW-1:0] OpW0      = 5'd3;
  localparam logic [OpW-1:0] OpW1      = 5'd4;
  localparam logic [OpW-1:0] OpW2      = 5'd5;
  localparam logic [OpW-1:0] OpW3      = 5'd6;
  localparam logic [OpW-1:0] OpAccX0   = 5'd7;
  localparam logic [OpW-1:0] OpAccY0   = 5'd11;
  localparam logic [OpW-1:0] OpAccYEnd = 5'd14;
  localparam logic [OpW-1:0] OpPoint   = 5'd15;
  localparam logic [OpW-1:0] OpDxx     = 5'd16;
  localparam logic [OpW-1:0] OpDyy     = 5'd17;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SQRT = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  typedef struct packed {
    logic           load;
    logic           idle_resp;
    logic           op_en;
    logic [OpW-1:0] op;
    logic           sq_init;
    logic           sq_step;
    logic           finish;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bess_ctrl.sv -----
// Sequencing state machine for the sampler.
// Drives cmd_t to bess_datapath; depends on bess_pkg.
`default_nettype none
module bess_ctrl
  import bess_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    req_valid_i,
  input  wire logic    req_mode_i,
  output logic         req_ready_o,
  input  wire status_t st_i,
  output cmd_t         cmd_o
);

  state_e          state_q, state_d;
  logic [OpW-1:0]  op_q, op_d;
  logic [SqCntW-1:0] sq_q, sq_d;
  logic            acc;

  assign req_ready_o = (state_q == ST_IDLE) && st_i.out_free;
  assign acc         = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    sq_d    = sq_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (!req_mode_i) begin
            cmd_o.load = 1'b1;
          end else if (!st_i.active) begin
            cmd_o.idle_resp = 1'b1;
          end else begin
            state_d = ST_MUL;
            op_d    = '0;
          end
        end
      end
      ST_MUL: begin
        cmd_o.op_en = 1'b1;
        cmd_o.op    = op_q;
        if (op_q == OpW'(NumOps - 1)) begin
          state_d = ST_SQRT;
          sq_d    = '0;
        end else begin
          op_d = op_q + 1'b1;
        end
      end
      ST_SQRT: begin
        if (sq_q == '0) cmd_o.sq_init = 1'b1;
        else            cmd_o.sq_step = 1'b1;
        if (sq_q == SqCntW'(SqrtIters)) begin
          state_d = ST_FIN;
        end else begin
          sq_d = sq_q + 1'b1;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= '0;
      sq_q    <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      sq_q    <= sq_d;
    end
  end

  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> st_i.out_free) else $error("result register busy at finish");
  a_mul_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> st_i.active) else $error("step run without a curve");
  a_step_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && req_mode_i && st_i.active) |=> (state_q == ST_MUL))
    else $error("step request did not start evaluation");

endmodule
`default_nettype wire

// ----- hw/rtl/bess_datapath.sv -----
// Curve evaluation datapath: shared multiplier, accumulators, square root.
// Controlled by bess_ctrl through cmd_t; depends on bess_pkg.
`default_nettype none
module bess_datapath
  import bess_pkg::*;
#(
  parameter int unsigned STEPS = StepsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output status_t                st_o,
  input  wire logic              quad_i,
  input  wire logic [8*CoordW-1:0] coords_i,
  input  wire logic [CoordW-1:0] spacing_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic                   out_pv_o,
  output logic [CoordW-1:0]      out_x_o,
  output logic [CoordW-1:0]      out_y_o,
  output logic                   out_last_o
);

  localparam int unsigned RW   = $clog2(STEPS) + 1;
  localparam int unsigned TQ   = 65536 / STEPS;
  localparam int unsigned TR   = 65536 % STEPS;
  localparam int unsigned IdxW = 10;

  logic signed [CoordW-1:0] coord_q [8];
  logic              quad_q, active_q;
  logic [CoordW-1:0] spacing_q;
  logic signed [CoordW-1:0] prev_x_q, prev_y_q, px_q, py_q;
  logic [31:0]       run_q;
  logic [IdxW-1:0]   idx_q;
  logic [16:0]       t_q, u;
  logic [RW-1:0]     r_q;
  logic [32:0]       u2_q, ut_q, t2_q;
  logic [34:0]       w_q [4];
  logic signed [61:0] accx_q, accy_q;
  logic [49:0]       d2_q, rem_q, bit_q;
  logic [50:0]       root_q;
  logic              ov_q, opv_q, olast_q;
  logic [CoordW-1:0] ox_q, oy_q;

  logic signed [34:0] ma;
  logic signed [24:0] mb;
  logic signed [59:0] prod;
  logic [2:0]         cidx;
  logic [1:0]         widx;
  logic [61:0]        wr1, wr3;
  logic signed [24:0] dx, dy;
  logic signed [CoordW-1:0] rx, ry;
  logic [50:0]        trial;

  assign u    = 17'd65536 - t_q;
  assign prod = ma * mb;
  assign dx   = 25'(px_q) - 25'(prev_x_q);
  assign dy   = 25'(py_q) - 25'(prev_y_q);

  function automatic logic signed [CoordW-1:0] round_sat(input logic signed [61:0] a);
    logic signed [61:0] s;
    logic signed [29:0] v;
    s = a + 62'sd2147483648;
    v = 30'(s >>> 32);
    if (v > 30'sd8388607)        return 24'sh7FFFFF;
    else if (v < -30'sd8388608)  return 24'sh800000;
    else                         return v[CoordW-1:0];
  endfunction

  assign rx = round_sat(accx_q);
  assign ry = round_sat(accy_q);

  always_comb begin
    ma   = '0;
    mb   = '0;
    widx = '0;
    cidx = '0;
    if (cmd_i.op >= OpAccX0 && cmd_i.op <= OpAccYEnd) begin
      if (cmd_i.op >= OpAccY0) begin
        widx = 2'(cmd_i.op - OpAccY0);
        cidx = {widx, 1'b1};
      end else begin
        widx = 2'(cmd_i.op - OpAccX0);
        cidx = {widx, 1'b0};
      end
    end
    case (cmd_i.op)
      OpUU: begin ma = 35'(u);    mb = 25'(u); end
      OpUT: begin ma = 35'(u);    mb = 25'(t_q); end
      OpTT: begin ma = 35'(t_q);  mb = 25'(t_q); end
      OpW0: begin ma = 35'(u2_q); mb = 25'(u); end
      OpW1: begin ma = 35'(u2_q); mb = 25'(t_q); end
      OpW2: begin ma = 35'(ut_q); mb = 25'(t_q); end
      OpW3: begin ma = 35'(t2_q); mb = 25'(t_q); end
      OpDxx: begin ma = 35'(dx);  mb = dx; end
      OpDyy: begin ma = 35'(dy);  mb = dy; end
      default: begin
        ma = $signed({1'b0, w_q[widx][33:0]});
        mb = 25'(coord_q[cidx]);
      end
    endcase
  end

  // round the cubic weights half up from Q.48 to Q.32
  assign wr1 = (62'(prod) + 62'd32768) >> 16;
  assign wr3 = (62'(prod) * 62'd3 + 62'd32768) >> 16;
  assign trial = root_q + 51'(bit_q);

  logic signed [CoordW-1:0] ex, ey;
  logic              emit, last;
  logic [32:0]       rsum;
  logic [31:0]       rbase;
  logic [RW:0]       rnext;

  assign ex    = quad_q ? coord_q[4] : coord_q[6];
  assign ey    = quad_q ? coord_q[5] : coord_q[7];
  assign emit  = (px_q == coord_q[0] && py_q == coord_q[1]) ||
                 (px_q == ex && py_q == ey) || (run_q >= 32'(spacing_q));
  assign rbase = emit ? 32'd0 : run_q;
  assign rsum  = 33'(rbase) + 33'(root_q[25:0]);
  assign last  = (idx_q == IdxW'(STEPS - 1));
  assign rnext = (RW+1)'(r_q) + (RW+1)'(TR);

  assign st_o.active   = active_q;
  assign st_o.out_free = !ov_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      quad_q    <= 1'b0;
      spacing_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      run_q     <= '0;
      idx_q     <= '0;
      t_q       <= '0;
      r_q       <= RW'(STEPS / 2);
      ov_q      <= 1'b0;
      for (int i = 0; i < 8; i++) coord_q[i] <= '0;
    end else begin
      if (cmd_i.idle_resp || cmd_i.finish) ov_q <= 1'b1;
      else if (ov_q && out_ready_i)        ov_q <= 1'b0;
      if (cmd_i.load) begin
        quad_q    <= quad_i;
        spacing_q <= spacing_i;
        for (int i = 0; i < 8; i++) coord_q[i] <= coords_i[i*CoordW +: CoordW];
        prev_x_q  <= coords_i[CoordW-1:0];
        prev_y_q  <= coords_i[2*CoordW-1:CoordW];
        run_q     <= '0;
        idx_q     <= '0;
        t_q       <= '0;
        r_q       <= RW'(STEPS / 2);
        active_q  <= 1'b1;
      end
      if (cmd_i.finish) begin
        run_q    <= rsum[32] ? 32'hFFFF_FFFF : rsum[31:0];
        prev_x_q <= px_q;
        prev_y_q <= py_q;
        if (last) begin
          active_q <= 1'b0;
          idx_q    <= '0;
          t_q      <= '0;
          r_q      <= RW'(STEPS / 2);
        end else begin
          idx_q <= idx_q + 1'b1;
          if (rnext >= (RW+1)'(STEPS)) begin
            r_q <= RW'(rnext - (RW+1)'(STEPS));
            t_q <= t_q + 17'(TQ) + 17'd1;
          end else begin
            r_q <= RW'(rnext);
            t_q <= t_q + 17'(TQ);
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op_en) begin
      case (cmd_i.op)
        OpUU: u2_q <= prod[32:0];
        OpUT: ut_q <= prod[32:0];
        OpTT: t2_q <= prod[32:0];
        OpW0: w_q[0] <= quad_q ? 35'(u2_q) : wr1[34:0];
        OpW1: w_q[1] <= quad_q ? 35'({ut_q, 1'b0}) : wr3[34:0];
        OpW2: w_q[2] <= quad_q ? 35'(t2_q) : wr3[34:0];
        OpW3: w_q[3] <= quad_q ? 35'd0 : wr1[34:0];
        OpPoint: begin
          px_q <= rx;
          py_q <= ry;
        end
        OpDxx: d2_q <= prod[49:0];
        OpDyy: d2_q <= d2_q + prod[49:0];
        default: begin
          if (cmd_i.op == OpAccX0)      accx_q <= 62'(prod);
          else if (cmd_i.op < OpAccY0)  accx_q <= accx_q + 62'(prod);
          else if (cmd_i.op == OpAccY0) accy_q <= 62'(prod);
          else                          accy_q <= accy_q + 62'(prod);
        end
      endcase
    end
    if (cmd_i.sq_init) begin
      rem_q  <= d2_q;
      root_q <= '0;
      bit_q  <= 50'd1 << 48;
    end
    if (cmd_i.sq_step) begin
      if (51'(rem_q) >= trial) begin
        rem_q  <= rem_q - trial[49:0];
        root_q <= (root_q >> 1) + 51'(bit_q);
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.idle_resp) begin
      opv_q   <= 1'b0;
      ox_q    <= '0;
      oy_q    <= '0;
      olast_q <= 1'b1;
    end
    if (cmd_i.finish) begin
      opv_q   <= emit;
      ox_q    <= px_q;
      oy_q    <= py_q;
      olast_q <= last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_pv_o    = opv_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_last_o  = olast_q;

endmodule
`default_nettype wire

// ----- hw/rtl/bezier_even_spacing_sampler_top.sv -----
// Top level of the curve even-spacing sampler: stream ports, controller, datapath.
// Depends on bess_pkg, bess_ctrl and bess_datapath.
//
// A start request (tuser = 0) loads a cubic or quadratic curve and a spacing
// and gives no result. Each step request (tuser = 1) evaluates the curve at the
// next t = k/STEPS and returns one result: a multiply phase on the single shared
// multiplier, the bit-pair square root and a finish state; no new request is taken
// before that result is done. A step with no curve loaded answers in the next
// cycle with a zero point and tlast set. One request is in work at a time; the
// result sits in an output register until taken, and no request is taken while
// it waits there.
`default_nettype none
module bezier_even_spacing_sampler_top
  import bess_pkg::*;
#(
  parameter int unsigned STEPS = StepsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // quadratic, start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y,
  // end_x, end_y, spacing, zero pad
  input  wire logic [223:0] s_axis_tdata_i,
  input  wire logic         s_axis_tuser_i,   // mode
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [47:0]       m_axis_tdata_o,   // point_x, point_y
  output logic              m_axis_tuser_o,   // point_valid
  output logic              m_axis_tlast_o    // last_step
);

  cmd_t    cmd;
  status_t st;

  bess_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_mode_i  (s_axis_tuser_i),
    .req_ready_o (s_axis_tready_o),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  bess_datapath #(.STEPS(STEPS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .quad_i      (s_axis_tdata_i[0]),
    .coords_i    (s_axis_tdata_i[192:1]),
    .spacing_i   (s_axis_tdata_i[216:193]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_pv_o    (m_axis_tuser_o),
    .out_x_o     (m_axis_tdata_o[23:0]),
    .out_y_o     (m_axis_tdata_o[47:24]),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
`default_nettype wire

// ----- sim/bess_checker.sv -----
// Checker for the curve even-spacing sampler: watches both stream channels,
// predicts each step result from its own copy of the curve state and compares.
// Depends on no package; its port widths match the top level's.
`default_nettype none
module bess_checker #(
  parameter int unsigned STEPS = 1000
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  input  wire logic         s_axis_tready_i,
  input  wire logic [223:0] s_axis_tdata_i,
  input  wire logic         s_axis_tuser_i,
  input  wire logic         m_axis_tvalid_i,
  input  wire logic         m_axis_tready_i,
  input  wire logic [47:0]  m_axis_tdata_i,
  input  wire logic         m_axis_tuser_i,
  input  wire logic         m_axis_tlast_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam longint unsigned TOne = 64'd65536;

  typedef struct packed {
    logic        point_valid;
    logic [23:0] point_x;
    logic [23:0] point_y;
    logic        last_step;
  } point_t;

  point_t      expected_points[$];
  int unsigned step_idx;
  bit          active;
  bit          quad;
  int          coords[8];
  int unsigned spacing_q;
  int          last_x;
  int          last_y;
  int unsigned arc_run;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned b;
    rem  = v;
    root = 0;
    b    = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic int eval_axis(longint unsigned w[4], int axis);
    longint acc;
    longint r;
    acc = 0;
    for (int i = 0; i < (quad ? 3 : 4); i++) begin
      acc += longint'(w[i]) * longint'(coords[2*i+axis]);
    end
    acc += 64'sd1 << 31;
    r = acc >>> 32;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return int'(r);
  endfunction

  // Load a new curve from a start request.
  task automatic load_curve(logic [223:0] d);
    quad = d[0];
    for (int i = 0; i < 8; i++) coords[i] = int'($signed(d[1+24*i +: 24]));
    spacing_q = d[193 +: 24];
    last_x    = coords[0];
    last_y    = coords[1];
    arc_run   = 0;
    step_idx  = 0;
    active    = 1'b1;
  endtask

  task automatic sample_step(output point_t p);
    longint unsigned t, u, w[4], d2, sum;
    longint          dx, dy;
    int              px, py, ex, ey;
    bit              hit;
    if (!active) begin
      p = '{1'b0, 24'd0, 24'd0, 1'b1};
      return;
    end
    t = (longint'(step_idx) * TOne + STEPS / 2) / STEPS;
    if (t > TOne) t = TOne;
    u = TOne - t;
    if (quad) begin
      w[0] = u * u;
      w[1] = 2 * u * t;
      w[2] = t * t;
      w[3] = 0;
      ex = coords[4];
      ey = coords[5];
    end else begin
      w[0] = (u * u * u + 32768) >> 16;
      w[1] = (3 * u * u * t + 32768) >> 16;
      w[2] = (3 * u * t * t + 32768) >> 16;
      w[3] = (t * t * t + 32768) >> 16;
      ex = coords[6];
      ey = coords[7];
    end
    px = eval_axis(w, 0);
    py = eval_axis(w, 1);
    // emit test uses the run length before this step's distance
    hit = (px == coords[0] && py == coords[1]) || (px == ex && py == ey) ||
          arc_run >= spacing_q;
    if (hit) arc_run = 0;
    dx  = longint'(px) - longint'(last_x);
    dy  = longint'(py) - longint'(last_y);
    d2  = longint'(dx * dx) + longint'(dy * dy);
    sum = longint'(arc_run) + isqrt(d2);
    arc_run = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    last_x  = px;
    last_y  = py;
    p.point_valid = hit;
    p.point_x     = px[23:0];
    p.point_y     = py[23:0];
    p.last_step   = (step_idx + 1 >= STEPS);
    if (p.last_step) begin
      active   = 1'b0;
      step_idx = 0;
    end else begin
      step_idx = (step_idx + 1) & 10'h3FF;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    point_t got;
    if (!rst_ni) begin
      expected_points.delete();
      step_idx     = 0;
      active       = 1'b0;
      quad         = 1'b0;
      for (int i = 0; i < 8; i++) coords[i] = 0;
      spacing_q    = 0;
      last_x       = 0;
      last_y       = 0;
      arc_run      = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = '{m_axis_tuser_i, m_axis_tdata_i[23:0], m_axis_tdata_i[47:24],
                m_axis_tlast_i};
        if (expected_points.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_points.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"mismatch: expected valid=%b x=%h y=%h last=%b, ",
                        "got valid=%b x=%h y=%h last=%b"},
                       want.point_valid, want.point_x, want.point_y, want.last_step,
                       got.point_valid, got.point_x, got.point_y, got.last_step);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (!s_axis_tuser_i) begin
          load_curve(s_axis_tdata_i);
        end else begin
          sample_step(want);
          expected_points = {expected_points, want};
        end
      end
      pending_o = expected_points.size();
    end
  end

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Testbench top for the curve even-spacing sampler: clock, reset, stream stimulus
// with random gaps and stalls, and the verdict. Depends on bess_pkg,
// bezier_even_spacing_sampler_top and bess_checker.
`default_nettype none
module tb
  import bess_pkg::*;
();

  localparam int unsigned Steps = StepsDef;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [223:0] s_axis_tdata_i;
  logic         s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [47:0]  m_axis_tdata_o;
  logic         m_axis_tuser_o;
  logic         m_axis_tlast_o;
  int           fail_count;
  int           pending;
  bit           no_gaps;
  int           sent;

  localparam logic ModeStart = 1'b0;
  localparam logic ModeStep  = 1'b1;

  bezier_even_spacing_sampler_top #(.STEPS(Steps)) u_dut (.*);

  bess_checker #(.STEPS(Steps)) u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tuser_i(m_axis_tuser_o), .m_axis_tlast_i(m_axis_tlast_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hold a request from the falling edge until a rising edge takes it;
  // returns at the falling edge after that.
  task automatic send(logic mode, logic [223:0] d);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = mode;
    s_axis_tdata_i  = d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    sent++;
    if (sent % 300 == 0) no_gaps = ~no_gaps;
  endtask

  task automatic start_curve(logic q, logic [23:0] c[8], logic [23:0] spc);
    logic [223:0] d;
    d = '0;
    d[0] = q;
    for (int i = 0; i < 8; i++) d[1+24*i +: 24] = c[i];
    d[193 +: 24] = spc;
    send(ModeStart, d);
  endtask

  task automatic steps(int n);
    for (int i = 0; i < n; i++) send(ModeStep, 224'($urandom()));
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return 24'($urandom());
      1:       return 24'($signed(12'($urandom())));
      2:       return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed(18'($urandom())));
    endcase
  endfunction

  task automatic random_curve(int n);
    logic [23:0] c[8];
    logic [23:0] spc;
    for (int i = 0; i < 8; i++) c[i] = rand_coord();
    case ($urandom_range(0, 3))
      0:       spc = 24'($urandom());
      1:       spc = 24'd0;
      default: spc = 24'($urandom_range(0, 1 << 18));
    endcase
    start_curve(1'($urandom_range(0, 1)), c, spc);
    steps(n);
  endtask

  // Receiver: one random stall per result.
  initial begin
    int stall;
    bit ok;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      forever begin
        ok = m_axis_tvalid_o;
        @(negedge clk_i);
        if (ok) break;
      end
    end
  end

  initial begin
    logic [23:0] c[8];
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tdata_i  = '0;
    no_gaps = 1'b0;
    sent    = 0;
    rst_ni  = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // step with no curve loaded
    steps(2);
    // extreme corners, spacing zero
    c = '{24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
          24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000};
    start_curve(1'b0, c, 24'd0);
    steps(3);
    // quadratic, maximum spacing
    c = '{24'h800000, 24'h800000, 24'h7FFFFF, 24'h000100,
          24'h7FFFFF, 24'h7FFFFF, 24'h123456, 24'hFEDCBA};
    start_curve(1'b1, c, 24'hFFFFFF);
    steps(3);
    // degenerate curve: every point equals the start point
    c = '{default: 24'h000500};
    start_curve(1'b0, c, 24'hFFFFFF);
    steps(3);
    // one full curve to reach the final step, then two steps while idle
    random_curve(Steps);
    steps(2);

    while (sent < 1850) begin
      if ($urandom_range(0, 19) == 0) steps(1);
      else random_curve($urandom_range(1, 40));
    end

    s_axis_tvalid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("bezier_even_spacing_sampler_top test passed");
    end else begin
      $display("bezier_even_spacing_sampler_top test failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("bezier_even_spacing_sampler_top test failed");
    $finish;
  end

endmodule
`default_nettype wire
